FILE: src/bbt_pkg.sv
// bbt_pkg: shared constants, the command record and a helper for the
// Bollinger band tracker. No dependencies.
package bbt_pkg;

   localparam int MAX_WINDOW = 256;
   localparam int PTR_W      = $clog2(MAX_WINDOW);
   localparam int NW         = $clog2(MAX_WINDOW + 1);
   localparam int HELD_W     = $clog2(MAX_WINDOW + 2);

   localparam int PRICE_W    = 24;
   localparam int WL_W       = 9;
   localparam int MULT_W     = 16;
   localparam int SUM_W      = 32;
   localparam int SQ_W       = 56;
   localparam int MEAN_W     = 40;
   localparam int DEV_W      = 32;
   localparam int BAND_W     = 40;
   localparam int VAR_W      = 64;

   // n * sumsq, its difference with sum^2, and the shifted dividend
   localparam int A_W        = SQ_W + NW;
   localparam int DIVD_W     = A_W + 16;
   localparam int DIVR_W     = 2 * NW;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MULT   = 1'b1;

   localparam logic [WL_W-1:0]   WL_RESET   = 9'd20;
   localparam logic [WL_W-1:0]   WL_DEFAULT = 9'd20;
   localparam logic [MULT_W-1:0] MULT_ONE2  = 16'd8192;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 144;
   localparam int RSP_USER_W = 2;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [PTR_W-1:0]   rd_idx;
      logic [PTR_W-1:0]   wr_idx;
      logic               sub_old;
      logic [NW-1:0]      n;
      logic [MULT_W-1:0]  mult;
      logic               mv;
      logic               sv;
   } cmd_type;

   function automatic logic [NW-1:0] eff_window(input logic [WL_W-1:0] wl);
      logic [WL_W-1:0] t;
      logic [NW-1:0]   r;
      t = (wl < WL_W'(2)) ? WL_DEFAULT : wl;
      if (int'(t) > MAX_WINDOW) r = NW'(MAX_WINDOW);
      else r = NW'(t);
      return r;
   endfunction

endpackage

FILE: src/bbt_front.sv
// bbt_front: configuration registers, window bookkeeping and command issue.
// Depends on bbt_pkg.
module bbt_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bbt_pkg::REQ_DATA_W-1:0] req_tdata,   // [23:0] price
   input  logic [0:0]                     req_tuser,   // [0] revise_last
   input  logic                           csr_we,
   input  logic [bbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           win_clear,
   input  logic                           q_full,
   output logic                           q_push,
   output bbt_pkg::cmd_type               q_cmd
);

   logic [bbt_pkg::WL_W-1:0]   wl_ff, wl_in;
   logic [bbt_pkg::MULT_W-1:0] mult_ff, mult_in;
   logic [bbt_pkg::HELD_W-1:0] held_ff, held_in;
   logic [bbt_pkg::PTR_W-1:0]  wp_ff, wp_in;

   logic [bbt_pkg::NW-1:0]     n;
   logic [bbt_pkg::HELD_W-1:0] n_ext;
   logic [bbt_pkg::HELD_W-1:0] held_new;
   logic                       rev;
   logic                       accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;
   assign win_clear  = csr_we && (csr_index == bbt_pkg::REG_WINDOW);

   assign n     = bbt_pkg::eff_window(wl_ff);
   assign n_ext = bbt_pkg::HELD_W'(n);
   // revise with an empty window behaves as an append
   assign rev   = req_tuser[0] && (held_ff != '0);

   always_comb begin
      q_cmd.price = req_tdata[bbt_pkg::PRICE_W-1:0];
      q_cmd.n     = n;
      q_cmd.mult  = (mult_ff == '0) ? bbt_pkg::MULT_ONE2 : mult_ff;
      if (rev) begin
         q_cmd.rd_idx  = wp_ff - 1'b1;
         q_cmd.wr_idx  = wp_ff - 1'b1;
         q_cmd.sub_old = 1'b1;
         held_new      = held_ff;
      end else begin
         q_cmd.rd_idx  = wp_ff - n[bbt_pkg::PTR_W-1:0];
         q_cmd.wr_idx  = wp_ff;
         q_cmd.sub_old = held_ff >= n_ext;
         held_new      = (held_ff < n_ext + 1'b1) ? held_ff + 1'b1 : held_ff;
      end
      q_cmd.mv = held_new >= n_ext;
      q_cmd.sv = held_new >= n_ext + 1'b1;
   end

   always_comb begin
      wl_in   = wl_ff;
      mult_in = mult_ff;
      held_in = held_ff;
      wp_in   = wp_ff;
      if (win_clear) begin
         wl_in   = csr_wdata[bbt_pkg::WL_W-1:0];
         held_in = '0;
         wp_in   = '0;
      end else if (accept) begin
         held_in = held_new;
         if (!rev) wp_in = wp_ff + 1'b1;
      end
      if (csr_we && (csr_index == bbt_pkg::REG_MULT)) begin
         mult_in = csr_wdata[bbt_pkg::MULT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= bbt_pkg::WL_RESET;
         mult_ff <= bbt_pkg::MULT_ONE2;
         held_ff <= '0;
         wp_ff   <= '0;
      end else begin
         wl_ff   <= wl_in;
         mult_ff <= mult_in;
         held_ff <= held_in;
         wp_ff   <= wp_in;
      end
   end

endmodule

FILE: src/bbt_queue.sv
// bbt_queue: short command queue between front and back.
// Depends on bbt_pkg.
module bbt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bbt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output bbt_pkg::cmd_type head
);

   localparam int CNT_W = $clog2(bbt_pkg::QDEPTH + 1);

   bbt_pkg::cmd_type               slot_ff [bbt_pkg::QDEPTH];
   logic [bbt_pkg::QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(bbt_pkg::QDEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/bbt_div.sv
// bbt_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on bbt_pkg.
module bbt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bbt_pkg::DIVD_W-1:0] dividend,
   input  logic [bbt_pkg::DIVR_W-1:0] divisor,
   output logic                       done,
   output logic [bbt_pkg::DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(bbt_pkg::DIVD_W + 1);

   logic [bbt_pkg::DIVR_W-1:0] rem_ff, rem_in;
   logic [bbt_pkg::DIVR_W-1:0] dvs_ff, dvs_in;
   logic [bbt_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [bbt_pkg::DIVR_W:0]   trial;
   logic                       fits;

   assign trial    = {rem_ff, quo_ff[bbt_pkg::DIVD_W-1]};
   assign fits     = trial >= {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_W'(bbt_pkg::DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? bbt_pkg::DIVR_W'(trial - {1'b0, dvs_ff})
                       : trial[bbt_pkg::DIVR_W-1:0];
         quo_in = {quo_ff[bbt_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: src/bbt_back.sv
// bbt_back: sample ring, running sums, mean/variance division, square root,
// band arithmetic and the result register. Depends on bbt_pkg, bbt_div.
module bbt_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           win_clear,
   input  logic                           q_valid,
   input  bbt_pkg::cmd_type               q_head,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [bbt_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_UPD   = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_MLO   = 4'd3;
   localparam logic [3:0] S_MHI   = 4'd4;
   localparam logic [3:0] S_DIFF  = 4'd5;
   localparam logic [3:0] S_DMEAN = 4'd6;
   localparam logic [3:0] S_DVAR  = 4'd7;
   localparam logic [3:0] S_SQRT  = 4'd8;
   localparam logic [3:0] S_DEV   = 4'd9;
   localparam logic [3:0] S_PROD  = 4'd10;
   localparam logic [3:0] S_BAND  = 4'd11;

   localparam int SQW   = 2 * bbt_pkg::PRICE_W;
   localparam int LO_W  = 28;
   localparam int ALO_W = LO_W + bbt_pkg::NW;
   localparam int AHI_W = bbt_pkg::SQ_W - LO_W + bbt_pkg::NW;
   localparam int PROD_W = bbt_pkg::MULT_W + bbt_pkg::DEV_W + 1;
   localparam int ACC_W = bbt_pkg::MEAN_W + 12 + 1;
   localparam int ROOT_STEPS = bbt_pkg::VAR_W / 2;
   localparam int RC_W = $clog2(ROOT_STEPS);

   logic [3:0]                    state_ff, state_in;
   bbt_pkg::cmd_type              cmd_ff, cmd_in;
   logic [bbt_pkg::PRICE_W-1:0]   ring [bbt_pkg::MAX_WINDOW];
   logic [bbt_pkg::PRICE_W-1:0]   old_ff;
   logic [bbt_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [bbt_pkg::SQ_W-1:0]      sumsq_ff, sumsq_in;
   logic [SQW-1:0]                sq_old_ff, sq_old_in, sq_new_ff, sq_new_in;
   logic [ALO_W-1:0]              alo_ff, alo_in;
   logic [bbt_pkg::A_W-1:0]       a_ff, a_in, d_ff, d_in;
   logic [2*bbt_pkg::SUM_W-1:0]   b_ff, b_in;
   logic [bbt_pkg::MEAN_W-1:0]    mean_ff, mean_in;
   logic [bbt_pkg::VAR_W-1:0]     v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [RC_W-1:0]               rc_ff, rc_in;
   logic [bbt_pkg::DEV_W-1:0]     dev_ff, dev_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          ovalid_ff, ovalid_in;
   logic [bbt_pkg::RSP_DATA_W-1:0] odata_ff, odata_in;
   logic [bbt_pkg::RSP_USER_W-1:0] ouser_ff, ouser_in;

   logic                          div_start, div_done;
   logic [bbt_pkg::DIVD_W-1:0]    div_dividend, div_quo;
   logic [bbt_pkg::DIVR_W-1:0]    div_divisor;
   logic [bbt_pkg::PRICE_W-1:0]   old_val;
   logic [AHI_W-1:0]              ahi;
   logic [bbt_pkg::VAR_W-1:0]     root_trial;
   logic signed [ACC_W-1:0]       base, up_acc, lo_acc;

   bbt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_pop      = (state_ff == S_IDLE) && q_valid && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;

   assign old_val    = cmd_ff.sub_old ? old_ff : '0;
   assign ahi        = cmd_ff.n * sumsq_ff[bbt_pkg::SQ_W-1:LO_W];
   assign root_trial = res_ff + bit_ff;
   assign base       = $signed({1'b0, mean_ff, 12'b0});
   assign up_acc     = base + ACC_W'(prod_ff);
   assign lo_acc     = base - ACC_W'(prod_ff);

   // ring: read the outgoing sample on pop, write the new one in the next cycle (S_UPD)
   always_ff @(posedge clock) begin
      if (q_pop) old_ff <= ring[q_head.rd_idx];
      if (state_ff == S_UPD) ring[cmd_ff.wr_idx] <= cmd_ff.price;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      sq_old_in    = sq_old_ff;
      sq_new_in    = sq_new_ff;
      alo_in       = alo_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      d_in         = d_ff;
      mean_in      = mean_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rc_in        = rc_ff;
      dev_in       = dev_ff;
      prod_in      = prod_ff;
      ovalid_in    = ovalid_ff;
      odata_in     = odata_ff;
      ouser_in     = ouser_ff;
      div_start    = 1'b0;
      div_dividend = bbt_pkg::DIVD_W'({sum_ff, 8'b0});
      div_divisor  = bbt_pkg::DIVR_W'(cmd_ff.n);

      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               cmd_in   = q_head;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            sum_in    = sum_ff - bbt_pkg::SUM_W'(old_val)
                        + bbt_pkg::SUM_W'(cmd_ff.price);
            sq_old_in = old_val * old_val;
            sq_new_in = cmd_ff.price * cmd_ff.price;
            state_in  = S_SQ;
         end
         S_SQ: begin
            sumsq_in = sumsq_ff - bbt_pkg::SQ_W'(sq_old_ff)
                       + bbt_pkg::SQ_W'(sq_new_ff);
            state_in = S_MLO;
         end
         S_MLO: begin
            alo_in   = cmd_ff.n * sumsq_ff[LO_W-1:0];
            state_in = S_MHI;
         end
         S_MHI: begin
            a_in     = {ahi, {LO_W{1'b0}}} + bbt_pkg::A_W'(alo_ff);
            b_in     = sum_ff * sum_ff;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            // an inconsistent negative difference counts as zero
            d_in      = (a_ff > bbt_pkg::A_W'(b_ff)) ? a_ff - bbt_pkg::A_W'(b_ff) : '0;
            div_start = 1'b1;
            state_in  = S_DMEAN;
         end
         S_DMEAN: begin
            if (div_done) begin
               mean_in      = cmd_ff.mv ? div_quo[bbt_pkg::MEAN_W-1:0] : '0;
               div_start    = 1'b1;
               div_dividend = {d_ff, 16'b0};
               div_divisor  = cmd_ff.n * cmd_ff.n;
               state_in     = S_DVAR;
            end
         end
         S_DVAR: begin
            if (div_done) begin
               v_in     = div_quo[bbt_pkg::VAR_W-1:0];
               res_in   = '0;
               bit_in   = bbt_pkg::VAR_W'(1) << (bbt_pkg::VAR_W - 2);
               rc_in    = RC_W'(ROOT_STEPS - 1);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (v_ff >= root_trial) begin
               v_in   = v_ff - root_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            rc_in  = rc_ff - 1'b1;
            if (rc_ff == '0) state_in = S_DEV;
         end
         S_DEV: begin
            dev_in   = cmd_ff.sv ? res_ff[bbt_pkg::DEV_W-1:0] : '0;
            state_in = S_PROD;
         end
         S_PROD: begin
            prod_in  = $signed(cmd_ff.mult) * $signed({1'b0, dev_ff});
            state_in = S_BAND;
         end
         S_BAND: begin
            odata_in  = {lo_acc[bbt_pkg::BAND_W+11:12], up_acc[bbt_pkg::BAND_W+11:12],
                         dev_ff, mean_ff[bbt_pkg::DEV_W-1:0]};
            ouser_in  = {cmd_ff.sv, cmd_ff.mv};
            ovalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (win_clear) begin
         sum_in   = '0;
         sumsq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      sq_old_ff <= sq_old_in;
      sq_new_ff <= sq_new_in;
      alo_ff    <= alo_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      d_ff      <= d_in;
      mean_ff   <= mean_in;
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      rc_ff     <= rc_in;
      dev_ff    <= dev_in;
      prod_ff   <= prod_in;
      odata_ff  <= odata_in;
      ouser_ff  <= ouser_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sum_ff    <= '0;
         sumsq_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         sumsq_ff  <= sumsq_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

FILE: src/bollinger_band_tracker.sv
// Bollinger band tracker top level: front, command queue and back.
// Depends on bbt_pkg, bbt_front, bbt_queue, bbt_back.

// One price sample per transfer gives one result transfer: the moving mean
// over the last N samples (Q.8), the population deviation (Q.8) and the
// bands at mean +/- multiplier * deviation. Each sample's time in the back end
// is set by two 81-step bit-serial divisions (mean and variance) in the
// shared divider and the 32-step square root; a two-entry command queue
// lets the input side take samples while the back end works or a result
// waits. Write the window length only while the block is idle: it restarts
// the window from empty.
module bollinger_band_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bbt_pkg::REQ_DATA_W-1:0] req_tdata,   // [23:0] price
   input  logic [0:0]                     req_tuser,   // [0] revise_last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] middle_line, [63:32] std_dev, [103:64] upper_line, [143:104] lower_line
   output logic [bbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [bbt_pkg::RSP_USER_W-1:0] rsp_tuser,   // [0] mean_valid, [1] spread_valid
   input  logic                           csr_we,
   input  logic [bbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic             win_clear;
   logic             q_full, q_push, q_valid, q_pop;
   bbt_pkg::cmd_type q_cmd, q_head;

   bbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .win_clear  (win_clear),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   bbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   bbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .win_clear  (win_clear),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/bbt_checker.sv
// bbt_checker: port-level assertions for the Bollinger band tracker, bound
// to the top level. Depends on bbt_pkg.
module bbt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bbt_pkg::RSP_USER_W-1:0] rsp_tuser
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("mean nonzero before window filled");

   a_spread_implies_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("spread valid without mean valid");

   a_no_spread_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |->
         rsp_tdata[63:32] == 32'd0 && rsp_tdata[103:64] == rsp_tdata[143:104])
      else $error("bands apart with zero deviation");

endmodule

bind bollinger_band_tracker bbt_checker u_bbt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
